>>> hw/rtl/alhc_pkg.sv
// ----------------------------------------------------------------------------
// alhc_pkg
// Shared constants, types and helpers of the anagram letter histogram check.
// ----------------------------------------------------------------------------
`default_nettype none

package alhc_pkg;

  localparam int unsigned MAX_LEN_DEF = 256;
  localparam int unsigned NUM_CLASSES = 26;
  localparam int unsigned CLS_W       = $clog2(NUM_CLASSES);

  localparam logic [7:0] UPPER_FIRST = 8'd65;
  localparam logic [7:0] UPPER_LAST  = 8'd90;
  localparam logic [7:0] LOWER_FIRST = 8'd97;
  localparam logic [7:0] LOWER_LAST  = 8'd122;
  localparam logic [7:0] CASE_BIT    = 8'h20;

  typedef enum logic [1:0] {
    STATUS_ANAGRAM        = 2'd0,
    STATUS_LETTERS_DIFFER = 2'd1,
    STATUS_LENGTH         = 2'd2,
    STATUS_NON_LETTER     = 2'd3
  } status_t;

  typedef logic [CLS_W-1:0] cls_t;

  function automatic logic alpha_byte(input logic [7:0] b);
    return ((b >= UPPER_FIRST) && (b <= UPPER_LAST)) ||
           ((b >= LOWER_FIRST) && (b <= LOWER_LAST));
  endfunction

  // Non-letters map to class zero so that the address stays in range.
  function automatic cls_t letter_class(input logic [7:0] b);
    logic [7:0] folded;
    folded = (b | CASE_BIT) - LOWER_FIRST;
    return alpha_byte(b) ? folded[CLS_W-1:0] : '0;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/alhc_ram.sv
// ----------------------------------------------------------------------------
// alhc_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module alhc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 26
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/anagram_letter_histogram_check.sv
// ----------------------------------------------------------------------------
// anagram_letter_histogram_check
// Case-insensitive anagram check of two strings streamed side by side.
//
//   channel  direction  payload                                  handshake
//   in_      input      word_char/present, compared_char/present, last
//                                                                in_valid/ready
//   out_     output     match, status                            out_valid/ready
//
// One character pair is taken per cycle while in_ready is high. Its read of
// the two letter count memories starts at the transfer and the update is
// written back when the pair commits, with a one-entry forward path for
// back-to-back hits. A result is registered when its last pair commits.
// Reset and every result clear the state at once through per-entry valid bits.
// Input stalls only while a last pair waits for a full, stalled output register.
// ----------------------------------------------------------------------------
`default_nettype none

module anagram_letter_histogram_check
  import alhc_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_word_char,
  input  wire logic       in_word_present,
  input  wire logic [7:0] in_compared_char,
  input  wire logic       in_compared_present,
  input  wire logic       in_last,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_match,
  output logic [1:0]      out_status,
  output logic            out_valid,
  input  wire logic       out_ready
);

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned POS_W = $clog2(MAX_LEN + 2);
  localparam int unsigned NZ_W  = $clog2(NUM_CLASSES + 1);

  typedef logic [CNT_W-1:0] cnt_t;

  logic adv;

  logic s1_valid_r, s1_valid_nxt;
  logic s1_wp_r, s1_cp_r, s1_last_r, s1_wl_r, s1_cl_r;
  cls_t s1_wcls_r, s1_ccls_r;
  cls_t in_wcls, in_ccls;

  logic [POS_W-1:0] pos_r, pos_nxt, pos_new;
  logic [NZ_W-1:0]  nz_r, nz_nxt, nz_new;
  logic             lenbad_r, lenbad_nxt, lenbad_new;
  logic             ltrbad_r, ltrbad_nxt, ltrbad_new;

  logic [NUM_CLASSES-1:0] a_vld_r, a_vld_nxt, b_vld_r, b_vld_nxt;

  logic fa_en_r, fa_en_nxt, fb_en_r, fb_en_nxt;
  cls_t fa_addr_r, fa_addr_nxt, fb_addr_r, fb_addr_nxt;
  cnt_t fa_data_r, fa_data_nxt, fb_data_r, fb_data_nxt;

  cnt_t a_q0, a_q1, b_q0, b_q1;
  cnt_t a_w, a_c, b_w, b_c;
  cnt_t a_wr, b_wr;

  logic commit, any_p, over, ew, ec, same;
  logic nz_inc_w, nz_dec_w, nz_inc_c, nz_dec_c;
  status_t status_new;

  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;

  assign adv      = !(s1_valid_r && s1_last_r && out_valid_r && !out_ready);
  assign in_ready = adv;
  assign commit   = s1_valid_r && adv;
  assign in_wcls  = letter_class(in_word_char);
  assign in_ccls  = letter_class(in_compared_char);

  alhc_ram #(.WIDTH(CNT_W), .DEPTH(NUM_CLASSES)) u_word_ram (
    .clk    (clk),
    .we     (ew && commit),
    .waddr  (s1_wcls_r),
    .wdata  (a_wr),
    .re     (adv),
    .raddr0 (in_wcls),
    .raddr1 (in_ccls),
    .rdata0 (a_q0),
    .rdata1 (a_q1)
  );

  alhc_ram #(.WIDTH(CNT_W), .DEPTH(NUM_CLASSES)) u_compared_ram (
    .clk    (clk),
    .we     (ec && commit),
    .waddr  (s1_ccls_r),
    .wdata  (b_wr),
    .re     (adv),
    .raddr0 (in_wcls),
    .raddr1 (in_ccls),
    .rdata0 (b_q0),
    .rdata1 (b_q1)
  );

  always_comb begin
    if (fa_en_r && (fa_addr_r == s1_wcls_r)) begin
      a_w = fa_data_r;
    end else begin
      a_w = a_vld_r[s1_wcls_r] ? a_q0 : '0;
    end
    if (fa_en_r && (fa_addr_r == s1_ccls_r)) begin
      a_c = fa_data_r;
    end else begin
      a_c = a_vld_r[s1_ccls_r] ? a_q1 : '0;
    end
    if (fb_en_r && (fb_addr_r == s1_wcls_r)) begin
      b_w = fb_data_r;
    end else begin
      b_w = b_vld_r[s1_wcls_r] ? b_q0 : '0;
    end
    if (fb_en_r && (fb_addr_r == s1_ccls_r)) begin
      b_c = fb_data_r;
    end else begin
      b_c = b_vld_r[s1_ccls_r] ? b_q1 : '0;
    end
  end

  always_comb begin
    any_p   = s1_wp_r || s1_cp_r;
    pos_new = pos_r;
    if (any_p && (pos_r <= POS_W'(MAX_LEN))) begin
      pos_new = pos_r + POS_W'(1);
    end
    over       = pos_new > POS_W'(MAX_LEN);
    lenbad_new = lenbad_r || (s1_wp_r != s1_cp_r) || (any_p && over);
    ltrbad_new = ltrbad_r || (s1_wp_r && !s1_wl_r) || (s1_cp_r && !s1_cl_r);
    ew         = s1_wp_r && s1_wl_r && !over;
    ec         = s1_cp_r && s1_cl_r && !over;
    same       = ew && ec && (s1_wcls_r == s1_ccls_r);
    a_wr       = a_w + cnt_t'(1);
    b_wr       = b_c + cnt_t'(1);

    nz_inc_w = ew && !same && (a_w == b_w);
    nz_dec_w = ew && !same && ({1'b0, a_w} + (CNT_W+1)'(1) == {1'b0, b_w});
    nz_inc_c = ec && !same && (a_c == b_c);
    nz_dec_c = ec && !same && ({1'b0, a_c} == {1'b0, b_c} + (CNT_W+1)'(1));
    nz_new   = nz_r + NZ_W'(nz_inc_w) + NZ_W'(nz_inc_c)
                    - NZ_W'(nz_dec_w) - NZ_W'(nz_dec_c);

    if (lenbad_new) begin
      status_new = STATUS_LENGTH;
    end else if (ltrbad_new) begin
      status_new = STATUS_NON_LETTER;
    end else if (nz_new != '0) begin
      status_new = STATUS_LETTERS_DIFFER;
    end else begin
      status_new = STATUS_ANAGRAM;
    end
  end

  always_comb begin
    s1_valid_nxt   = s1_valid_r;
    pos_nxt        = pos_r;
    nz_nxt         = nz_r;
    lenbad_nxt     = lenbad_r;
    ltrbad_nxt     = ltrbad_r;
    a_vld_nxt      = a_vld_r;
    b_vld_nxt      = b_vld_r;
    fa_en_nxt      = fa_en_r;
    fa_addr_nxt    = fa_addr_r;
    fa_data_nxt    = fa_data_r;
    fb_en_nxt      = fb_en_r;
    fb_addr_nxt    = fb_addr_r;
    fb_data_nxt    = fb_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;

    if (adv) begin
      s1_valid_nxt = in_valid;
      fa_en_nxt    = 1'b0;
      fb_en_nxt    = 1'b0;
    end

    if (commit) begin
      fa_en_nxt   = ew && !s1_last_r;
      fa_addr_nxt = s1_wcls_r;
      fa_data_nxt = a_wr;
      fb_en_nxt   = ec && !s1_last_r;
      fb_addr_nxt = s1_ccls_r;
      fb_data_nxt = b_wr;
      if (s1_last_r) begin
        pos_nxt        = '0;
        nz_nxt         = '0;
        lenbad_nxt     = 1'b0;
        ltrbad_nxt     = 1'b0;
        a_vld_nxt      = '0;
        b_vld_nxt      = '0;
        out_valid_nxt  = 1'b1;
        out_status_nxt = status_new;
      end else begin
        pos_nxt    = pos_new;
        nz_nxt     = nz_new;
        lenbad_nxt = lenbad_new;
        ltrbad_nxt = ltrbad_new;
        if (ew) begin
          a_vld_nxt[s1_wcls_r] = 1'b1;
        end
        if (ec) begin
          b_vld_nxt[s1_ccls_r] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      pos_r       <= '0;
      nz_r        <= '0;
      lenbad_r    <= 1'b0;
      ltrbad_r    <= 1'b0;
      a_vld_r     <= '0;
      b_vld_r     <= '0;
      fa_en_r     <= 1'b0;
      fb_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      pos_r       <= pos_nxt;
      nz_r        <= nz_nxt;
      lenbad_r    <= lenbad_nxt;
      ltrbad_r    <= ltrbad_nxt;
      a_vld_r     <= a_vld_nxt;
      b_vld_r     <= b_vld_nxt;
      fa_en_r     <= fa_en_nxt;
      fb_en_r     <= fb_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fa_addr_r    <= fa_addr_nxt;
    fa_data_r    <= fa_data_nxt;
    fb_addr_r    <= fb_addr_nxt;
    fb_data_r    <= fb_data_nxt;
    out_status_r <= out_status_nxt;
    if (adv) begin
      s1_wp_r   <= in_word_present;
      s1_cp_r   <= in_compared_present;
      s1_last_r <= in_last;
      s1_wl_r   <= alpha_byte(in_word_char);
      s1_cl_r   <= alpha_byte(in_compared_char);
      s1_wcls_r <= in_wcls;
      s1_ccls_r <= in_ccls;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_match  = (out_status_r == STATUS_ANAGRAM);

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the anagram letter histogram check. A directed
// table of character pairs comes first, then random strings: anagrams,
// near misses, length mismatches, strings with non-letters, noise, and a few
// strings at and past the length limit. Every verdict is compared with a typed
// row's expected status or a predictor that keeps its own letter balances,
// under random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top
  import alhc_pkg::*;
();

  localparam int LEN_CAP     = MAX_LEN_DEF;
  localparam int ITEMS       = 1700;
  localparam int QUIET_FROM  = 1450;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 40;
  localparam int LIMIT       = 400000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [7:0] wc;
    logic       wp;
    logic [7:0] cc;
    logic       cp;
    logic       last;
  } pair_t;

  typedef struct packed {
    pair_t   p;
    logic    typed;
    status_t want;
  } dir_row_t;

  typedef enum {
    SK_ANAGRAM,
    SK_NEAR,
    SK_LENGTH,
    SK_GLYPH,
    SK_NOISE,
    SK_SKEW
  } shape_t;

  logic       clk;
  logic       rst_n;
  pair_t      drv_pair;
  logic       cur_typed;
  status_t    cur_want;
  logic [7:0] in_word_char;
  logic       in_word_present;
  logic [7:0] in_compared_char;
  logic       in_compared_present;
  logic       in_last;
  logic       in_valid;
  logic       in_ready;
  logic       out_match;
  logic [1:0] out_status;
  logic       out_valid;
  logic       out_ready;

  int         tally [NUM_CLASSES];
  int         unmatched;
  int         span_cnt;
  logic       span_bad;
  logic       glyph_bad;

  status_t    verdict_q [$];
  status_t    pred;
  status_t    head;
  pair_t      pending_q [$];
  dir_row_t   dir_tab [$];
  int         err_cnt;
  int         verdicts_seen;
  int         cycle_cnt;
  logic       quiet;
  logic       hold_done;

  assign in_word_char        = drv_pair.wc;
  assign in_word_present     = drv_pair.wp;
  assign in_compared_char    = drv_pair.cc;
  assign in_compared_present = drv_pair.cp;
  assign in_last             = drv_pair.last;

  anagram_letter_histogram_check uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_word_char        (in_word_char),
    .in_word_present     (in_word_present),
    .in_compared_char    (in_compared_char),
    .in_compared_present (in_compared_present),
    .in_last             (in_last),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .out_match           (out_match),
    .out_status          (out_status),
    .out_valid           (out_valid),
    .out_ready           (out_ready)
  );

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  function automatic logic letter_byte(logic [7:0] b);
    return ((b >= UPPER_FIRST) && (b <= UPPER_LAST)) ||
           ((b >= LOWER_FIRST) && (b <= LOWER_LAST));
  endfunction

  function automatic int class_of(logic [7:0] b);
    return int'(8'(b | CASE_BIT) - LOWER_FIRST);
  endfunction

  function automatic void fold_in(logic [7:0] b, int delta);
    int cls;
    int prior;
    if (!letter_byte(b)) begin
      glyph_bad = 1'b1;
      return;
    end
    if (span_cnt > LEN_CAP) return;
    cls = class_of(b);
    prior = tally[cls];
    tally[cls] = prior + delta;
    if (prior == 0) begin
      unmatched++;
    end else if (tally[cls] == 0) begin
      unmatched--;
    end
  endfunction

  function automatic logic tally_pair(pair_t p, output status_t verdict);
    if (p.wp != p.cp) span_bad = 1'b1;
    if (p.wp || p.cp) begin
      if (span_cnt <= LEN_CAP) span_cnt++;
      if (span_cnt > LEN_CAP) span_bad = 1'b1;
      if (p.wp) fold_in(p.wc, 1);
      if (p.cp) fold_in(p.cc, -1);
    end
    verdict = STATUS_ANAGRAM;
    if (!p.last) return 1'b0;
    if (span_bad) begin
      verdict = STATUS_LENGTH;
    end else if (glyph_bad) begin
      verdict = STATUS_NON_LETTER;
    end else if (unmatched != 0) begin
      verdict = STATUS_LETTERS_DIFFER;
    end
    foreach (tally[i]) tally[i] = 0;
    unmatched = 0;
    span_cnt  = 0;
    span_bad  = 1'b0;
    glyph_bad = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] letter_of(int cls);
    return 8'(LOWER_FIRST + 8'(cls)) ^ ($urandom_range(0, 1) ? CASE_BIT : 8'h00);
  endfunction

  function automatic logic [7:0] non_letter();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (letter_byte(b));
    return b;
  endfunction

  function automatic dir_row_t mk_row(logic [7:0] wc, logic wp, logic [7:0] cc,
                                      logic cp, logic last, logic typed,
                                      status_t want);
    dir_row_t r;
    r.p.wc  = wc;
    r.p.wp  = wp;
    r.p.cc  = cc;
    r.p.cp  = cp;
    r.p.last = last;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  task automatic offer_pair(input pair_t p, input logic typed, input status_t want);
    int gap;
    if (!quiet && ($urandom_range(0, 4) == 0)) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    drv_pair  <= p;
    cur_typed <= typed;
    cur_want  <= want;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
  endtask

  task automatic compose_string(input int idx);
    logic [7:0] w [$];
    logic [7:0] c [$];
    logic [7:0] t;
    pair_t      p;
    shape_t     kind;
    int         len;
    int         n;
    int         j;
    int         r;
    int         a;
    int         b;
    pending_q.delete();
    if (idx == 15 || idx == 35 || idx == 55 || idx == 75) begin
      len  = (idx == 55) ? LEN_CAP + 1 : (idx == 75) ? LEN_CAP + 3 : LEN_CAP;
      kind = (idx == 15) ? SK_SKEW : (idx == 75) ? SK_NEAR : SK_ANAGRAM;
    end else begin
      r    = $urandom_range(0, 15);
      kind = (r < 9) ? SK_ANAGRAM : (r < 11) ? SK_NEAR : (r < 13) ? SK_LENGTH :
             (r < 15) ? SK_GLYPH : SK_NOISE;
      len  = (kind == SK_ANAGRAM) ? $urandom_range(0, 12) : $urandom_range(1, 12);
    end

    if (kind == SK_SKEW) begin
      a = $urandom_range(0, 25);
      b = (a + $urandom_range(1, 25)) % NUM_CLASSES;
      for (int k = 0; k < len; k++) begin
        w.push_back(letter_of(a));
        c.push_back(letter_of(b));
      end
    end else if (kind == SK_NOISE) begin
      n = $urandom_range(0, 12);
      for (int k = 0; k < len; k++) w.push_back(8'($urandom_range(0, 255)));
      for (int k = 0; k < n; k++) c.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (int k = 0; k < len; k++) begin
        w.push_back(letter_of($urandom_range(0, 25)));
        c.push_back(w[k] ^ ($urandom_range(0, 1) ? CASE_BIT : 8'h00));
      end
      for (int k = len - 1; k > 0; k--) begin
        j    = $urandom_range(0, k);
        t    = c[k];
        c[k] = c[j];
        c[j] = t;
      end
      if (kind == SK_NEAR) begin
        j    = $urandom_range(0, len - 1);
        c[j] = letter_of((class_of(c[j]) + $urandom_range(1, 25)) % NUM_CLASSES);
      end else if (kind == SK_LENGTH) begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          if (r[0]) begin
            w.push_back(letter_of($urandom_range(0, 25)));
          end else begin
            c.push_back(letter_of($urandom_range(0, 25)));
          end
        end
      end else if (kind == SK_GLYPH) begin
        j = $urandom_range(0, len - 1);
        if ($urandom_range(0, 1)) begin
          w[j] = non_letter();
        end else begin
          c[j] = non_letter();
        end
      end
    end

    n = (w.size() > c.size()) ? w.size() : c.size();
    if (n == 0) n = 1;
    for (int k = 0; k < n; k++) begin
      p.wp   = (k < w.size());
      p.wc   = p.wp ? w[k] : 8'($urandom_range(0, 255));
      p.cp   = (k < c.size());
      p.cc   = p.cp ? c[k] : 8'($urandom_range(0, 255));
      p.last = (k == n - 1);
      if (kind == SK_NOISE) begin
        p.wp = $urandom_range(0, 1);
        p.cp = $urandom_range(0, 1);
      end
      pending_q.push_back(p);
    end
    if ($urandom_range(0, 7) == 0) begin
      p.wc   = 8'($urandom_range(0, 255));
      p.wp   = 1'b0;
      p.cc   = 8'($urandom_range(0, 255));
      p.cp   = 1'b0;
      p.last = 1'b0;
      pending_q.insert($urandom_range(0, pending_q.size() - 1), p);
    end
  endtask

  initial begin : stimulus
    int sent;
    int str_idx;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    drv_pair  = '0;
    cur_typed = 1'b0;
    cur_want  = STATUS_ANAGRAM;
    quiet     = 1'b0;

    dir_tab.push_back(mk_row(8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, STATUS_ANAGRAM));
    dir_tab.push_back(mk_row(UPPER_FIRST, 1'b1, LOWER_FIRST, 1'b1, 1'b1, 1'b1,
                             STATUS_ANAGRAM));
    dir_tab.push_back(mk_row(UPPER_LAST, 1'b1, LOWER_LAST, 1'b1, 1'b1, 1'b1,
                             STATUS_ANAGRAM));
    dir_tab.push_back(mk_row(8'd97, 1'b1, 8'd98, 1'b1, 1'b1, 1'b1,
                             STATUS_LETTERS_DIFFER));
    dir_tab.push_back(mk_row(8'd65, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1, STATUS_LENGTH));
    dir_tab.push_back(mk_row(8'h00, 1'b0, 8'd122, 1'b1, 1'b1, 1'b1, STATUS_LENGTH));
    dir_tab.push_back(mk_row(8'd64, 1'b1, 8'd64, 1'b1, 1'b1, 1'b1, STATUS_NON_LETTER));
    dir_tab.push_back(mk_row(8'd91, 1'b1, 8'd91, 1'b1, 1'b1, 1'b1, STATUS_NON_LETTER));
    dir_tab.push_back(mk_row(8'd96, 1'b1, 8'd123, 1'b1, 1'b1, 1'b1,
                             STATUS_NON_LETTER));
    dir_tab.push_back(mk_row(8'h00, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, STATUS_NON_LETTER));
    dir_tab.push_back(mk_row(8'h80, 1'b1, 8'd97, 1'b0, 1'b1, 1'b1, STATUS_LENGTH));
    dir_tab.push_back(mk_row(8'd84, 1'b1, 8'd101, 1'b1, 1'b0, 1'b0, STATUS_ANAGRAM));
    dir_tab.push_back(mk_row(8'd101, 1'b1, 8'd65, 1'b1, 1'b0, 1'b0, STATUS_ANAGRAM));
    dir_tab.push_back(mk_row(8'd97, 1'b1, 8'd116, 1'b1, 1'b1, 1'b0, STATUS_ANAGRAM));
    dir_tab.push_back(mk_row(8'd67, 1'b1, 8'd67, 1'b1, 1'b0, 1'b0, STATUS_ANAGRAM));
    dir_tab.push_back(mk_row(8'h5A, 1'b0, 8'hA5, 1'b0, 1'b0, 1'b0, STATUS_ANAGRAM));
    dir_tab.push_back(mk_row(8'd100, 1'b1, 8'd68, 1'b1, 1'b1, 1'b0, STATUS_ANAGRAM));
    dir_tab.push_back(mk_row(8'd49, 1'b1, 8'd49, 1'b1, 1'b0, 1'b0, STATUS_ANAGRAM));
    dir_tab.push_back(mk_row(8'd97, 1'b1, 8'd98, 1'b1, 1'b1, 1'b0, STATUS_ANAGRAM));
    dir_tab.push_back(mk_row(8'd120, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_ANAGRAM));
    dir_tab.push_back(mk_row(8'h00, 1'b0, 8'd120, 1'b1, 1'b1, 1'b0, STATUS_ANAGRAM));
    dir_tab.push_back(mk_row(8'd97, 1'b1, 8'd98, 1'b1, 1'b0, 1'b0, STATUS_ANAGRAM));
    dir_tab.push_back(mk_row(8'hFF, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, STATUS_ANAGRAM));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) offer_pair(dir_tab[i].p, dir_tab[i].typed, dir_tab[i].want);
    sent    = dir_tab.size();
    str_idx = 0;
    while (sent < ITEMS) begin
      compose_string(str_idx);
      foreach (pending_q[i]) offer_pair(pending_q[i], 1'b0, STATUS_ANAGRAM);
      sent += pending_q.size();
      str_idx++;
      if (sent >= QUIET_FROM) quiet = 1'b1;
    end
    in_valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // The long hold-off lets the sender keep going so the block backs up.
  initial begin : receiver
    int n;
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!hold_done && verdicts_seen >= HOLD_AFTER) begin
        out_ready <= 1'b0;
        hold_done = 1'b1;
        n = HOLD_CYCLES;
      end else if (!quiet && ($urandom_range(0, 4) == 0)) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 13);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 40);
      end
      repeat (n) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (tally_pair(drv_pair, pred)) begin
        verdict_q.push_back(cur_typed ? cur_want : pred);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= REPORT_MAX) begin
          $display("unexpected result transfer: match=%0b status=%0d",
                   out_match, out_status);
        end
      end else begin
        head = verdict_q.pop_front();
        if (out_status !== head || out_match !== (head == STATUS_ANAGRAM)) begin
          err_cnt++;
          if (err_cnt <= REPORT_MAX) begin
            $display("verdict mismatch: expected match=%0b status=%0d,",
                     head == STATUS_ANAGRAM, head,
                     " got match=%0b status=%0d", out_match, out_status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
